@@ sv/gpool_pkg.sv @@
`timescale 1ns / 1ps

package gpool_pkg;

    // Default sizing of the slot table.
    localparam int SLOTS_DEF    = 256;
    localparam int GEN_BITS_DEF = 32;

    // Command codes carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_GET    = 2'd1,
        CMD_REMOVE = 2'd2
    } gpool_cmd_t;

    // One result word as it leaves the execute stage.
    typedef struct packed {
        logic        ok;
        logic [7:0]  slot_index;
        logic [31:0] slot_generation;
        logic [7:0]  live_count;
    } gpool_result_t;

endpackage

@@ sv/gpool_store.sv @@
`timescale 1ns / 1ps

module gpool_store
    import gpool_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int GEN_BITS = GEN_BITS_DEF,
    localparam int IDX_W   = $clog2(SLOTS)
)
(
    input  logic                clk,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output logic [GEN_BITS-1:0] gen_rd,
    output logic [IDX_W-1:0]    link_rd,
    input  logic                gen_we,
    input  logic                link_we,
    input  logic [IDX_W-1:0]    wr_addr,
    input  logic [GEN_BITS-1:0] gen_wd,
    input  logic [IDX_W-1:0]    link_wd
);

    // Per-slot generation (top bit marks a free slot) and free-list links.
    logic [GEN_BITS-1:0] gen_mem  [SLOTS];
    logic [IDX_W-1:0]    link_mem [SLOTS];

    logic [GEN_BITS-1:0] gen_rd_reg;
    logic [IDX_W-1:0]    link_rd_reg;

    // Registered read; the data holds until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            gen_rd_reg  <= gen_mem[rd_addr];
            link_rd_reg <= link_mem[rd_addr];
        end
    end

    // Write port shared by both arrays.
    always_ff @(posedge clk)
    begin
        if (gen_we)
        begin
            gen_mem[wr_addr] <= gen_wd;
        end
        if (link_we)
        begin
            link_mem[wr_addr] <= link_wd;
        end
    end

    assign gen_rd  = gen_rd_reg;
    assign link_rd = link_rd_reg;

endmodule

@@ sv/gpool_exec.sv @@
`timescale 1ns / 1ps

module gpool_exec
    import gpool_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int GEN_BITS = GEN_BITS_DEF,
    localparam int IDX_W   = $clog2(SLOTS)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  gpool_cmd_t          cmd,
    input  logic [7:0]          handle_index,
    input  logic [31:0]         handle_generation,
    input  logic [GEN_BITS-1:0] gen_rd,
    input  logic [IDX_W-1:0]    link_rd,
    output logic [IDX_W-1:0]    free_head,
    output logic                gen_we,
    output logic                link_we,
    output logic [IDX_W-1:0]    wr_addr,
    output logic [GEN_BITS-1:0] gen_wd,
    output logic [IDX_W-1:0]    link_wd,
    output gpool_result_t       result
);

    localparam int HW_W  = $clog2(SLOTS + 1);
    localparam int CW    = (HW_W > 9) ? HW_W : 9;
    localparam int CMP_W = (GEN_BITS > 32) ? GEN_BITS : 32;
    localparam logic [GEN_BITS-1:0] SLOT_FREE_FLAG = {1'b1, {(GEN_BITS-1){1'b0}}};

    logic [IDX_W-1:0] free_head_reg, free_head_next;
    logic [HW_W-1:0]  high_water_reg, high_water_next;
    logic [7:0]       count_reg, count_next;

    logic [CW-1:0]       idx_c;
    logic [IDX_W-1:0]    idx_addr;
    logic                in_range;
    logic [CMP_W-1:0]    gen_rd_ext;
    logic [CMP_W-1:0]    hgen_ext;
    logic [IDX_W-1:0]    slot;
    logic [CW-1:0]       slot_c;
    logic [GEN_BITS-1:0] gen_out;
    logic [CMP_W-1:0]    gen_out_ext;
    logic                ok;
    logic                gen_wr;
    logic                link_wr;

    // Range check of the handle index against zero, the high-water mark and SLOTS.
    assign idx_c      = CW'(handle_index);
    assign idx_addr   = IDX_W'(idx_c);
    assign in_range   = (idx_c != '0) && (idx_c < CW'(high_water_reg))
                        && (idx_c < CW'(SLOTS));
    assign gen_rd_ext = CMP_W'(gen_rd);
    assign hgen_ext   = CMP_W'(handle_generation);

    // Read-modify-write of the slot fetched when the command was accepted.
    always_comb
    begin
        free_head_next  = free_head_reg;
        high_water_next = high_water_reg;
        count_next      = count_reg;
        gen_wr          = 1'b0;
        link_wr         = 1'b0;
        wr_addr         = idx_addr;
        gen_wd          = gen_rd;
        link_wd         = free_head_reg;
        slot            = idx_addr;
        gen_out         = gen_rd;
        ok              = 1'b0;
        case (cmd)
            CMD_ADD:
            begin
                if (free_head_reg != '0)
                begin
                    slot           = free_head_reg;
                    free_head_next = link_rd;
                    gen_wd         = gen_rd & ~SLOT_FREE_FLAG;
                    gen_wr         = 1'b1;
                    ok             = 1'b1;
                end
                else if (high_water_reg < HW_W'(SLOTS))
                begin
                    slot            = IDX_W'(high_water_reg);
                    high_water_next = high_water_reg + HW_W'(1);
                    gen_wd          = '0;
                    gen_wr          = 1'b1;
                    ok              = 1'b1;
                end
                wr_addr = slot;
                gen_out = gen_wd;
                if (ok && (count_reg != 8'hFF))
                begin
                    count_next = count_reg + 8'd1;
                end
            end
            CMD_GET:
            begin
                ok = in_range && (gen_rd_ext == hgen_ext);
            end
            CMD_REMOVE:
            begin
                if (in_range)
                begin
                    gen_wd         = (gen_rd + GEN_BITS'(1)) | SLOT_FREE_FLAG;
                    gen_wr         = 1'b1;
                    link_wr        = 1'b1;
                    free_head_next = idx_addr;
                    gen_out        = gen_wd;
                    ok             = 1'b1;
                    if (count_reg != 8'd0)
                    begin
                        count_next = count_reg - 8'd1;
                    end
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Result word; failures report zero index and generation.
    assign slot_c      = CW'(slot);
    assign gen_out_ext = CMP_W'(gen_out);

    always_comb
    begin
        result.ok              = ok;
        result.slot_index      = ok ? slot_c[7:0] : 8'd0;
        result.slot_generation = ok ? gen_out_ext[31:0] : 32'd0;
        result.live_count      = count_next;
    end

    assign gen_we    = fire && gen_wr;
    assign link_we   = fire && link_wr;
    assign free_head = free_head_reg;

    // Pool bookkeeping registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= '0;
            high_water_reg <= HW_W'(1);
            count_reg      <= 8'd0;
        end
        else if (fire)
        begin
            free_head_reg  <= free_head_next;
            high_water_reg <= high_water_next;
            count_reg      <= count_next;
        end
    end

endmodule

@@ sv/generational_handle_pool_top.sv @@
`timescale 1ns / 1ps

// Channel  Dir  tuser              tdata
// s_*      in   [1:0] cmd          [7:0] handle_index, [39:8] handle_generation
// m_*      out  [0] ok             [7:0] slot_index, [39:8] slot_generation,
//                                  [47:40] live_count
//
// The accept cycle in ST_IDLE issues the registered slot read; the execute
// state ST_EXEC then modifies and writes the slot back. Reset empties the
// free list, sets the high-water mark to one and clears the live count; the
// slot memories need no clearing. A new command is accepted while a result
// waits in the output register; the execute cycle holds until that register
// is free.

module generational_handle_pool_top
    import gpool_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int GEN_BITS = GEN_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    input  logic [39:0] s_tdata,   // [7:0] handle_index, [39:8] handle_generation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,   // [0] ok
    output logic [47:0] m_tdata    // [7:0] slot_index, [39:8] slot_generation,
                                   // [47:40] live_count
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int AW_IN = (IDX_W > 8) ? IDX_W : 8;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    gpool_cmd_t    cmd_reg;
    logic [7:0]    idx_reg;
    logic [31:0]   hgen_reg;
    logic          out_valid_reg, out_valid_next;
    gpool_result_t out_data_reg;

    logic                s_fire;
    logic                exec_fire;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    free_head;
    logic [GEN_BITS-1:0] gen_rd;
    logic [IDX_W-1:0]    link_rd;
    logic                gen_we;
    logic                link_we;
    logic [IDX_W-1:0]    wr_addr;
    logic [GEN_BITS-1:0] gen_wd;
    logic [IDX_W-1:0]    link_wd;
    gpool_result_t       result;

    // Handshakes.
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    // Add reads the free-list head; get and remove read the handle slot.
    assign rd_addr = (gpool_cmd_t'(s_tuser) == CMD_ADD)
                     ? free_head : IDX_W'(AW_IN'(s_tdata[7:0]));

    // Command sequencing.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Captured command and result payload.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cmd_reg  <= gpool_cmd_t'(s_tuser);
            idx_reg  <= s_tdata[7:0];
            hgen_reg <= s_tdata[39:8];
        end
        if (exec_fire)
        begin
            out_data_reg <= result;
        end
    end

    gpool_store #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS)
    ) u_store (
        .clk     (clk),
        .rd_en   (s_fire),
        .rd_addr (rd_addr),
        .gen_rd  (gen_rd),
        .link_rd (link_rd),
        .gen_we  (gen_we),
        .link_we (link_we),
        .wr_addr (wr_addr),
        .gen_wd  (gen_wd),
        .link_wd (link_wd)
    );

    gpool_exec #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS)
    ) u_exec (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (exec_fire),
        .cmd               (cmd_reg),
        .handle_index      (idx_reg),
        .handle_generation (hgen_reg),
        .gen_rd            (gen_rd),
        .link_rd           (link_rd),
        .free_head         (free_head),
        .gen_we            (gen_we),
        .link_we           (link_we),
        .wr_addr           (wr_addr),
        .gen_wd            (gen_wd),
        .link_wd           (link_wd),
        .result            (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.ok;
    assign m_tdata  = {out_data_reg.live_count, out_data_reg.slot_generation,
                       out_data_reg.slot_index};

endmodule

@@ tb/tb_generational_handle_pool_top.sv @@
`timescale 1ns / 1ps

module tb_generational_handle_pool_top;

    import gpool_pkg::*;

    // The command code the block does not define; it must change nothing.
    localparam logic [1:0]  CMD_NONE       = 2'd3;
    localparam logic [31:0] SLOT_FREE_FLAG = 32'h8000_0000;
    localparam int          CYCLE_LIMIT    = 1_000_000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          RANDOM_WORDS   = 1100;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;   // [1:0] cmd
    logic [39:0] s_tdata;   // [7:0] handle_index, [39:8] handle_generation
    logic        m_tvalid;
    logic        m_tready;
    logic        m_tuser;   // [0] ok
    logic [47:0] m_tdata;   // [7:0] slot_index, [39:8] slot_generation, [47:40] live_count

    generational_handle_pool_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the slot table, kept in step with every accepted word.
    logic [31:0] slot_gen  [SLOTS_DEF];
    logic [7:0]  slot_link [SLOTS_DEF];
    logic [7:0]  free_top;
    logic [8:0]  fresh_mark;
    logic [7:0]  live_slots;

    // Answers predicted for words already sent, oldest first.
    gpool_result_t pending_answers [$];

    int  cycle_count;
    int  mismatch_count;
    int  add_words;
    int  get_words;
    int  remove_words;
    int  none_words;
    int  ok_answers;
    int  full_rejects;
    int  count_clamps;
    int  peak_live;
    bit  tx_busy;
    bit  rx_eager;
    bit  rx_hold_req;
    int  rx_stall_left;

    // Clock with a 10 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Run limit: a stuck handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, pending_answers.size());
            $display("status: fail");
            $finish;
        end
    end

    // Predict the answer to one command and advance the shadow table.
    function automatic gpool_result_t pool_answer(input logic [1:0] cmd,
                                                  input logic [7:0] idx,
                                                  input logic [31:0] hgen);
        gpool_result_t res;
        logic [7:0]    slot;
        logic          in_range;
        res      = '0;
        in_range = (idx != 8'd0) && ({1'b0, idx} < fresh_mark);
        if (cmd == CMD_ADD)
        begin
            // Reuse the most recently freed slot, else take a fresh one.
            if (free_top != 8'd0)
            begin
                slot           = free_top;
                free_top       = slot_link[slot];
                slot_gen[slot] = slot_gen[slot] & ~SLOT_FREE_FLAG;
            end
            else if (fresh_mark < SLOTS_DEF)
            begin
                slot           = fresh_mark[7:0];
                fresh_mark     = fresh_mark + 9'd1;
                slot_gen[slot] = 32'd0;
            end
            else
            begin
                full_rejects++;
                res.live_count = live_slots;
                return res;
            end
            if (live_slots != 8'hFF)
                live_slots = live_slots + 8'd1;
            else
                count_clamps++;
            res.ok              = 1'b1;
            res.slot_index      = slot;
            res.slot_generation = slot_gen[slot];
        end
        else if (cmd == CMD_GET)
        begin
            if (in_range && slot_gen[idx] == hgen)
            begin
                res.ok              = 1'b1;
                res.slot_index      = idx;
                res.slot_generation = slot_gen[idx];
            end
        end
        else if (cmd == CMD_REMOVE)
        begin
            // Removal bumps the generation, marks the slot free and pushes it.
            if (in_range)
            begin
                slot_gen[idx]  = (slot_gen[idx] + 32'd1) | SLOT_FREE_FLAG;
                slot_link[idx] = free_top;
                free_top       = idx;
                if (live_slots != 8'd0)
                    live_slots = live_slots - 8'd1;
                else
                    count_clamps++;
                res.ok              = 1'b1;
                res.slot_index      = idx;
                res.slot_generation = slot_gen[idx];
            end
        end
        res.live_count = live_slots;
        return res;
    endfunction

    // Sender gap: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_busy || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Offer one command word and wait until the block takes it.
    task automatic send_word(input logic [1:0] cmd, input logic [7:0] idx,
                             input logic [31:0] hgen);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {hgen, idx};
        pending_answers.push_back(pool_answer(cmd, idx, hgen));
        if (pending_answers[$].ok)
            ok_answers++;
        if (live_slots > peak_live)
            peak_live = live_slots;
        case (cmd)
            CMD_ADD:    add_words++;
            CMD_GET:    get_words++;
            CMD_REMOVE: remove_words++;
            default:    none_words++;
        endcase
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Any nonzero index below the high-water mark, or index one when there is none.
    function automatic logic [7:0] live_index();
        if (fresh_mark < 9'd2)
            return 8'd1;
        return 8'($urandom_range(1, fresh_mark - 1));
    endfunction

    // One random word, mostly well-formed handles with some noise mixed in.
    task automatic send_random_word();
        int          r;
        int          v;
        logic [7:0]  idx;
        logic [31:0] hgen;
        r    = $urandom_range(0, 99);
        v    = $urandom_range(0, 99);
        idx  = live_index();
        hgen = slot_gen[idx];
        if (r < 30)
            send_word(CMD_ADD, 8'($urandom), $urandom);
        else if (r < 62)
        begin
            // Valid handle, one flipped bit, toggled free bit or pure noise.
            if (v < 50)
                send_word(CMD_GET, idx, hgen);
            else if (v < 70)
                send_word(CMD_GET, idx, hgen ^ (32'd1 << $urandom_range(0, 31)));
            else if (v < 85)
                send_word(CMD_GET, idx, hgen ^ SLOT_FREE_FLAG);
            else
                send_word(CMD_GET, 8'($urandom), $urandom);
        end
        else if (r < 90)
        begin
            if (v < 85)
                send_word(CMD_REMOVE, idx, $urandom);
            else
                send_word(CMD_REMOVE, 8'($urandom), $urandom);
        end
        else
            send_word(CMD_NONE, 8'($urandom), $urandom);
    endtask

    // Receiver: random stalls, idle-free stretches and one long hold-off.
    always @(negedge clk)
    begin : rx_side
        int r;
        if (rx_hold_req)
        begin
            rx_hold_req   = 1'b0;
            rx_stall_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left = rx_stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (rx_eager)
            m_tready <= 1'b1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                rx_stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 60);
            end
        end
    end

    // Compare every answer word with the oldest prediction.
    always @(posedge clk)
    begin : answer_check
        gpool_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected answer word: ok %0b index %0d gen %h live %0d",
                             m_tuser, m_tdata[7:0], m_tdata[39:8], m_tdata[47:40]);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (m_tuser !== want.ok || m_tdata[7:0] !== want.slot_index ||
                    m_tdata[39:8] !== want.slot_generation ||
                    m_tdata[47:40] !== want.live_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $write("answer mismatch: expected ok %0b index %0d gen %h live %0d,",
                               want.ok, want.slot_index, want.slot_generation,
                               want.live_count);
                        $display(" got ok %0b index %0d gen %h live %0d",
                                 m_tuser, m_tdata[7:0], m_tdata[39:8], m_tdata[47:40]);
                    end
                end
            end
        end
    end

    // Edge cases from an empty table: range checks, stale handles, reuse order.
    task automatic test_directed_cases();
        send_word(CMD_GET, 8'd0, 32'd0);
        send_word(CMD_REMOVE, 8'd0, 32'd0);
        send_word(CMD_GET, 8'hFF, 32'hFFFF_FFFF);
        send_word(CMD_NONE, 8'hFF, 32'hFFFF_FFFF);
        send_word(CMD_ADD, 8'd0, 32'd0);
        send_word(CMD_ADD, 8'd0, 32'd0);
        send_word(CMD_ADD, 8'd0, 32'd0);
        send_word(CMD_GET, 8'd1, 32'd0);
        send_word(CMD_GET, 8'd1, SLOT_FREE_FLAG);
        send_word(CMD_GET, 8'd2, 32'd1);
        send_word(CMD_REMOVE, 8'd2, 32'd0);
        send_word(CMD_GET, 8'd2, 32'd0);
        // A handle carrying the free bit still matches a freed slot.
        send_word(CMD_GET, 8'd2, SLOT_FREE_FLAG | 32'd1);
        send_word(CMD_ADD, 8'd0, 32'd0);
        send_word(CMD_GET, 8'd2, 32'd1);
        send_word(CMD_REMOVE, 8'd3, 32'd0);
        send_word(CMD_REMOVE, 8'd1, 32'hFFFF_FFFF);
        send_word(CMD_ADD, 8'd0, 32'd0);
        send_word(CMD_ADD, 8'd0, 32'd0);
        send_word(CMD_ADD, 8'd0, 32'd0);
        send_word(CMD_REMOVE, 8'hFF, 32'd0);
        send_word(CMD_ADD, 8'hFF, 32'hFFFF_FFFF);
        send_word(CMD_GET, 8'd4, 32'd0);
    endtask

    // Allocate every slot, check that further adds are refused, then free and reuse a slot.
    task automatic test_table_full();
        while (free_top != 8'd0 || fresh_mark < SLOTS_DEF)
            send_word(CMD_ADD, 8'($urandom), $urandom);
        send_word(CMD_ADD, 8'd0, 32'd0);
        send_word(CMD_ADD, 8'hFF, 32'hFFFF_FFFF);
        send_word(CMD_GET, 8'hFF, slot_gen[255]);
        send_word(CMD_REMOVE, 8'hFF, 32'd0);
        send_word(CMD_ADD, 8'd0, 32'd0);
        send_word(CMD_ADD, 8'd0, 32'd0);
    endtask

    // Hold the receiver off while the sender keeps offering words back to back.
    task automatic test_backpressure();
        tx_busy     = 1'b1;
        rx_hold_req = 1'b1;
        repeat (40) send_random_word();
        tx_busy = 1'b0;
    endtask

    // Drain the live count to zero, remove a free slot, then overfill the count.
    task automatic test_count_limits();
        for (int i = 1; i < SLOTS_DEF; i++)
            send_word(CMD_REMOVE, 8'(i), $urandom);
        send_word(CMD_REMOVE, 8'd7, 32'd0);
        repeat (258) send_word(CMD_ADD, 8'($urandom), $urandom);
    endtask

    // Random traffic with idle-free bursts every so often.
    task automatic test_random_traffic(input int words);
        for (int n = 0; n < words; n++)
        begin
            tx_busy  = (n % 200) >= 160;
            rx_eager = tx_busy;
            send_random_word();
        end
        tx_busy  = 1'b0;
        rx_eager = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = CMD_ADD;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cycle_count    = 0;
        mismatch_count = 0;
        add_words      = 0;
        get_words      = 0;
        remove_words   = 0;
        none_words     = 0;
        ok_answers     = 0;
        full_rejects   = 0;
        count_clamps   = 0;
        peak_live      = 0;
        tx_busy        = 1'b0;
        rx_eager       = 1'b0;
        rx_hold_req    = 1'b0;
        rx_stall_left  = 0;
        free_top       = 8'd0;
        fresh_mark     = 9'd1;
        live_slots     = 8'd0;
        for (int i = 0; i < SLOTS_DEF; i++)
        begin
            slot_gen[i]  = 32'd0;
            slot_link[i] = 8'd0;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_table_full();
        test_backpressure();
        test_count_limits();
        test_random_traffic(RANDOM_WORDS);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d adds, %0d gets, %0d removes and %0d undefined commands",
                 add_words, get_words, remove_words, none_words);
        $display("%0d accepted, %0d refused on a full table, %0d count clamps, peak live %0d",
                 ok_answers, full_rejects, count_clamps, peak_live);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
